// File: hw/rtl/biou_pkg.sv
package biou_pkg;

  localparam int MQ_DEPTH = 8;
  localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);

endpackage

// File: hw/rtl/biou_fifo.sv
module biou_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             pop,
  output logic [WIDTH-1:0]                 rdata,
  output logic                             empty,
  output logic [$clog2(DEPTH + 1)-1:0]     count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

// File: hw/rtl/biou_front.sv
module biou_front
  import biou_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [COORD_BITS-1:0]  in_a_x,
  input  logic signed [COORD_BITS-1:0]  in_a_y,
  input  logic [COORD_BITS-2:0]         in_a_width,
  input  logic [COORD_BITS-2:0]         in_a_height,
  input  logic signed [COORD_BITS-1:0]  in_b_x,
  input  logic signed [COORD_BITS-1:0]  in_b_y,
  input  logic [COORD_BITS-2:0]         in_b_width,
  input  logic [COORD_BITS-2:0]         in_b_height,
  input  logic [MQ_CNT_W-1:0]           mq_count,
  output logic                          mq_push,
  output logic [2+6*(COORD_BITS-1)-1:0] mq_data
);

  localparam int CB = COORD_BITS;
  localparam int SB = COORD_BITS - 1;
  localparam int PW = 2 * SB;

  logic                accept;
  logic [MQ_CNT_W-1:0] fl_r, fl_nxt;

  // stage 1: far corners
  logic                 s1_v_r;
  logic signed [CB-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;
  logic signed [CB:0]   s1_amx_r, s1_amy_r, s1_bmx_r, s1_bmy_r;
  logic signed [CB:0]   s1_amx_nxt, s1_amy_nxt, s1_bmx_nxt, s1_bmy_nxt;
  logic [SB-1:0]        s1_aw_r, s1_ah_r, s1_bw_r, s1_bh_r;

  // stage 2: intersection bounds, containment
  logic                 s2_v_r;
  logic signed [CB-1:0] s2_x0_r, s2_y0_r, s2_x0_nxt, s2_y0_nxt;
  logic signed [CB:0]   s2_x1_r, s2_y1_r, s2_x1_nxt, s2_y1_nxt;
  logic                 s2_in_r, s2_in_nxt;
  logic [SB-1:0]        s2_aw_r, s2_ah_r, s2_bw_r, s2_bh_r;

  // stage 3: intersection extents, overlap
  logic                 s3_v_r;
  logic signed [CB+1:0] dx, dy;
  logic [SB-1:0]        s3_wx_r, s3_wy_r, s3_wx_nxt, s3_wy_nxt;
  logic                 s3_ov_r, s3_ov_nxt;
  logic                 s3_in_r;
  logic [SB-1:0]        s3_aw_r, s3_ah_r, s3_bw_r, s3_bh_r;

  // stage 4: areas
  logic                 s4_v_r;
  logic [PW-1:0]        s4_inter_r, s4_aa_r, s4_ab_r;
  logic [PW-1:0]        s4_inter_nxt, s4_aa_nxt, s4_ab_nxt;
  logic                 s4_ov_r, s4_in_r;

  assign in_full = ({1'b0, mq_count} + {1'b0, fl_r}) >= (MQ_CNT_W + 1)'(MQ_DEPTH);
  assign accept  = in_push && !in_full;
  assign mq_push = s4_v_r;
  assign mq_data = {s4_ov_r, s4_in_r, s4_inter_r, s4_aa_r, s4_ab_r};

  always_comb begin
    fl_nxt     = fl_r + MQ_CNT_W'(accept) - MQ_CNT_W'(mq_push);

    s1_amx_nxt = $signed({in_a_x[CB-1], in_a_x}) + $signed({2'b00, in_a_width});
    s1_amy_nxt = $signed({in_a_y[CB-1], in_a_y}) + $signed({2'b00, in_a_height});
    s1_bmx_nxt = $signed({in_b_x[CB-1], in_b_x}) + $signed({2'b00, in_b_width});
    s1_bmy_nxt = $signed({in_b_y[CB-1], in_b_y}) + $signed({2'b00, in_b_height});

    s2_x0_nxt  = (s1_ax_r > s1_bx_r) ? s1_ax_r : s1_bx_r;
    s2_y0_nxt  = (s1_ay_r > s1_by_r) ? s1_ay_r : s1_by_r;
    s2_x1_nxt  = (s1_amx_r < s1_bmx_r) ? s1_amx_r : s1_bmx_r;
    s2_y1_nxt  = (s1_amy_r < s1_bmy_r) ? s1_amy_r : s1_bmy_r;
    s2_in_nxt  = (s1_ax_r >= s1_bx_r) && (s1_ay_r >= s1_by_r) &&
                 (s1_amx_r <= s1_bmx_r) && (s1_amy_r <= s1_bmy_r);

    dx         = $signed({s2_x1_r[CB], s2_x1_r}) - $signed({{2{s2_x0_r[CB-1]}}, s2_x0_r});
    dy         = $signed({s2_y1_r[CB], s2_y1_r}) - $signed({{2{s2_y0_r[CB-1]}}, s2_y0_r});
    s3_wx_nxt  = dx[SB-1:0];
    s3_wy_nxt  = dy[SB-1:0];
    s3_ov_nxt  = !dx[CB+1] && (dx != '0) && !dy[CB+1] && (dy != '0);

    s4_inter_nxt = PW'(s3_wx_r) * PW'(s3_wy_r);
    s4_aa_nxt    = PW'(s3_aw_r) * PW'(s3_ah_r);
    s4_ab_nxt    = PW'(s3_bw_r) * PW'(s3_bh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fl_r   <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      fl_r   <= fl_nxt;
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ax_r    <= in_a_x;
    s1_ay_r    <= in_a_y;
    s1_bx_r    <= in_b_x;
    s1_by_r    <= in_b_y;
    s1_amx_r   <= s1_amx_nxt;
    s1_amy_r   <= s1_amy_nxt;
    s1_bmx_r   <= s1_bmx_nxt;
    s1_bmy_r   <= s1_bmy_nxt;
    s1_aw_r    <= in_a_width;
    s1_ah_r    <= in_a_height;
    s1_bw_r    <= in_b_width;
    s1_bh_r    <= in_b_height;

    s2_x0_r    <= s2_x0_nxt;
    s2_y0_r    <= s2_y0_nxt;
    s2_x1_r    <= s2_x1_nxt;
    s2_y1_r    <= s2_y1_nxt;
    s2_in_r    <= s2_in_nxt;
    s2_aw_r    <= s1_aw_r;
    s2_ah_r    <= s1_ah_r;
    s2_bw_r    <= s1_bw_r;
    s2_bh_r    <= s1_bh_r;

    s3_wx_r    <= s3_wx_nxt;
    s3_wy_r    <= s3_wy_nxt;
    s3_ov_r    <= s3_ov_nxt;
    s3_in_r    <= s2_in_r;
    s3_aw_r    <= s2_aw_r;
    s3_ah_r    <= s2_ah_r;
    s3_bw_r    <= s2_bw_r;
    s3_bh_r    <= s2_bh_r;

    s4_inter_r <= s4_inter_nxt;
    s4_aa_r    <= s4_aa_nxt;
    s4_ab_r    <= s4_ab_nxt;
    s4_ov_r    <= s3_ov_r;
    s4_in_r    <= s3_in_r;
  end

endmodule

// File: hw/rtl/biou_back.sv
module biou_back #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  parameter int OQ_DEPTH   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              mq_empty,
  input  logic [2+6*(COORD_BITS-1)-1:0]     mq_data,
  output logic                              mq_pop,
  input  logic [$clog2(OQ_DEPTH + 1)-1:0]   oq_count,
  output logic                              oq_push,
  output logic [FRAC_BITS+1:0]              oq_data
);

  localparam int SB       = COORD_BITS - 1;
  localparam int PW       = 2 * SB;
  localparam int UW       = PW + 1;
  localparam int RW       = PW + 2;
  localparam int QW       = FRAC_BITS + 1;
  localparam int NDIV     = FRAC_BITS + 1;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  logic                ov_in, ins_in;
  logic [PW-1:0]       inter_in, aa_in, ab_in;
  logic [OQ_CNT_W-1:0] fl_r, fl_nxt;

  // union stage
  logic                u_v_r;
  logic                u_ov_r, u_in_r;
  logic [RW-1:0]       u_rem_r;
  logic [UW-1:0]       u_den_r, u_den_nxt;

  // divider stages, one quotient bit each
  logic                d_v_r   [NDIV];
  logic                d_ov_r  [NDIV];
  logic                d_in_r  [NDIV];
  logic [RW-1:0]       d_rem_r [NDIV];
  logic [UW-1:0]       d_den_r [NDIV];
  logic [QW-1:0]       d_q_r   [NDIV];

  logic                p_v     [NDIV];
  logic                p_ov    [NDIV];
  logic                p_in    [NDIV];
  logic [RW-1:0]       p_rem   [NDIV];
  logic [UW-1:0]       p_den   [NDIV];
  logic [QW-1:0]       p_q     [NDIV];

  logic [RW-1:0]       d_rem_nxt [NDIV];
  logic [QW-1:0]       d_q_nxt   [NDIV];

  assign {ov_in, ins_in, inter_in, aa_in, ab_in} = mq_data;

  assign mq_pop  = !mq_empty &&
                   (({1'b0, fl_r} + {1'b0, oq_count}) < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign oq_push = d_v_r[NDIV-1];
  assign oq_data = {(d_ov_r[NDIV-1] ? d_q_r[NDIV-1] : QW'(0)), d_in_r[NDIV-1]};

  always_comb begin
    fl_nxt    = fl_r + OQ_CNT_W'(mq_pop) - OQ_CNT_W'(oq_push);
    u_den_nxt = {1'b0, aa_in} + {1'b0, ab_in} - {1'b0, inter_in};
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_src
    if (k == 0) begin : g_first
      assign p_v[k]   = u_v_r;
      assign p_ov[k]  = u_ov_r;
      assign p_in[k]  = u_in_r;
      assign p_rem[k] = u_rem_r;
      assign p_den[k] = u_den_r;
      assign p_q[k]   = '0;
    end else begin : g_next
      assign p_v[k]   = d_v_r[k-1];
      assign p_ov[k]  = d_ov_r[k-1];
      assign p_in[k]  = d_in_r[k-1];
      assign p_rem[k] = d_rem_r[k-1];
      assign p_den[k] = d_den_r[k-1];
      assign p_q[k]   = d_q_r[k-1];
    end
  end

  always_comb begin
    logic          ge;
    logic [RW-1:0] rsub;
    for (int k = 0; k < NDIV; k++) begin
      ge                       = p_rem[k] >= {1'b0, p_den[k]};
      rsub                     = ge ? p_rem[k] - {1'b0, p_den[k]} : p_rem[k];
      d_rem_nxt[k]             = {rsub[RW-2:0], 1'b0};
      d_q_nxt[k]               = p_q[k];
      d_q_nxt[k][NDIV-1-k]     = ge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fl_r  <= '0;
      u_v_r <= 1'b0;
      for (int k = 0; k < NDIV; k++) begin
        d_v_r[k] <= 1'b0;
      end
    end else begin
      fl_r  <= fl_nxt;
      u_v_r <= mq_pop;
      for (int k = 0; k < NDIV; k++) begin
        d_v_r[k] <= p_v[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    u_ov_r  <= ov_in;
    u_in_r  <= ins_in;
    u_rem_r <= {2'b00, inter_in};
    u_den_r <= u_den_nxt;
    for (int k = 0; k < NDIV; k++) begin
      d_ov_r[k]  <= p_ov[k];
      d_in_r[k]  <= p_in[k];
      d_rem_r[k] <= d_rem_nxt[k];
      d_den_r[k] <= p_den[k];
      d_q_r[k]   <= d_q_nxt[k];
    end
  end

endmodule

// File: hw/rtl/box_iou_and_containment.sv
// Axis-aligned box IoU and containment. Each transaction carries boxes A and B
// (signed origin, unsigned size); the result is floor(inter * 2^FRAC_BITS / union)
// on out_iou (2^FRAC_BITS means identical boxes, 0 for disjoint or touching boxes)
// and out_a_inside_b, set when A lies within B with edges inclusive. One transaction
// is accepted and one result delivered per clock when out_pop keeps up. Each result
// passes through four front-end stages (corners, bounds, extents, area multipliers),
// a hand-off queue, a union stage, and a pipelined restoring divider that resolves
// one quotient bit per stage. The output queue absorbs results in flight when out_pop
// is held low; in_full rises once the queues are committed.
module box_iou_and_containment
  import biou_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic [COORD_BITS-2:0]        in_a_width,
  input  logic [COORD_BITS-2:0]        in_a_height,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic [COORD_BITS-2:0]        in_b_width,
  input  logic [COORD_BITS-2:0]        in_b_height,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [FRAC_BITS:0]           out_iou,
  output logic                         out_a_inside_b
);

  localparam int MID_W    = 2 + 6 * (COORD_BITS - 1);
  localparam int OQ_DEPTH = 1 << $clog2(FRAC_BITS + 4);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
  localparam int OUT_W    = FRAC_BITS + 2;

  logic                mq_push, mq_pop, mq_empty;
  logic [MID_W-1:0]    mq_wdata, mq_rdata;
  logic [MQ_CNT_W-1:0] mq_count;

  logic                oq_push, oq_pop;
  logic [OUT_W-1:0]    oq_wdata, oq_rdata;
  logic [OQ_CNT_W-1:0] oq_count;

  biou_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_a_x      (in_a_x),
    .in_a_y      (in_a_y),
    .in_a_width  (in_a_width),
    .in_a_height (in_a_height),
    .in_b_x      (in_b_x),
    .in_b_y      (in_b_y),
    .in_b_width  (in_b_width),
    .in_b_height (in_b_height),
    .mq_count    (mq_count),
    .mq_push     (mq_push),
    .mq_data     (mq_wdata)
  );

  biou_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MQ_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty),
    .count (mq_count)
  );

  biou_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .OQ_DEPTH   (OQ_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mq_empty (mq_empty),
    .mq_data  (mq_rdata),
    .mq_pop   (mq_pop),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_data  (oq_wdata)
  );

  assign oq_pop = out_pop && !out_empty;

  biou_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .pop   (oq_pop),
    .rdata (oq_rdata),
    .empty (out_empty),
    .count (oq_count)
  );

  assign {out_iou, out_a_inside_b} = oq_rdata;

endmodule

// File: sim/tb_box_iou_and_containment.sv
module tb_box_iou_and_containment;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = FRAC_BITS + 16;

  typedef struct {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic [COORD_BITS-2:0]        a_width;
    logic [COORD_BITS-2:0]        a_height;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic [COORD_BITS-2:0]        b_width;
    logic [COORD_BITS-2:0]        b_height;
  } box_pair_t;

  typedef struct {
    logic [FRAC_BITS:0] iou;
    logic               a_inside_b;
  } iou_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_push;
  logic                         in_full;
  logic signed [COORD_BITS-1:0] in_a_x;
  logic signed [COORD_BITS-1:0] in_a_y;
  logic [COORD_BITS-2:0]        in_a_width;
  logic [COORD_BITS-2:0]        in_a_height;
  logic signed [COORD_BITS-1:0] in_b_x;
  logic signed [COORD_BITS-1:0] in_b_y;
  logic [COORD_BITS-2:0]        in_b_width;
  logic [COORD_BITS-2:0]        in_b_height;
  logic                         out_empty;
  logic                         out_pop;
  logic [FRAC_BITS:0]           out_iou;
  logic                         out_a_inside_b;

  iou_result_t pending_ious[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          pop_stall = 0;
  bit          steady_flow = 0;
  bit          hold_results = 0;

  box_iou_and_containment #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_a_x        (in_a_x),
    .in_a_y        (in_a_y),
    .in_a_width    (in_a_width),
    .in_a_height   (in_a_height),
    .in_b_x        (in_b_x),
    .in_b_y        (in_b_y),
    .in_b_width    (in_b_width),
    .in_b_height   (in_b_height),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_iou       (out_iou),
    .out_a_inside_b(out_a_inside_b)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("box_iou_and_containment: mismatch");
      $finish;
    end
  end

  function automatic iou_result_t predict_iou(box_pair_t p);
    iou_result_t r;
    longint ax, ay, aw, ah, bx, by, bw, bh;
    longint x0, x1, y0, y1, overlap, union_area;
    ax = longint'(p.a_x);
    ay = longint'(p.a_y);
    aw = longint'(p.a_width);
    ah = longint'(p.a_height);
    bx = longint'(p.b_x);
    by = longint'(p.b_y);
    bw = longint'(p.b_width);
    bh = longint'(p.b_height);
    x0 = (ax > bx) ? ax : bx;
    y0 = (ay > by) ? ay : by;
    x1 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
    y1 = (ay + ah < by + bh) ? ay + ah : by + bh;
    r.iou = '0;
    if (x0 < x1 && y0 < y1) begin
      overlap = (x1 - x0) * (y1 - y0);
      union_area = aw * ah + bw * bh - overlap;
      if (union_area != 0) r.iou = (FRAC_BITS + 1)'((overlap <<< FRAC_BITS) / union_area);
    end
    r.a_inside_b = (ax >= bx) && (ay >= by) && (ax + aw <= bx + bw) && (ay + ah <= by + bh);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return $urandom_range(0, 255);
      2: return $urandom_range(0, 4095);
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(0, 3) != 0) return int'($urandom_range(0, 1023)) - 512;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic box_pair_t random_box_pair();
    box_pair_t p;
    int ax, ay, aw, ah, bx, by, bw, bh;
    ax = pick_coord();
    ay = pick_coord();
    aw = pick_size();
    ah = pick_size();
    bx = pick_coord();
    by = pick_coord();
    bw = pick_size();
    bh = pick_size();
    case ($urandom_range(0, 9))
      0: begin
        ax = $urandom;
        ay = $urandom;
        aw = $urandom;
        ah = $urandom;
        bx = $urandom;
        by = $urandom;
        bw = $urandom;
        bh = $urandom;
      end
      1: begin
        bx = ax + int'($urandom_range(0, 2)) - 1;
        by = ay + int'($urandom_range(0, 2)) - 1;
        bw = aw;
        bh = ah;
      end
      2, 3: begin
        aw = $urandom_range(0, bw);
        ah = $urandom_range(0, bh);
        ax = bx + int'($urandom_range(0, bw - aw));
        ay = by + int'($urandom_range(0, bh - ah));
      end
      4, 5: begin
        bw = $urandom_range(0, aw);
        bh = $urandom_range(0, ah);
        bx = ax + int'($urandom_range(0, aw - bw));
        by = ay + int'($urandom_range(0, ah - bh));
      end
      default: begin
        bx = ax + int'($urandom_range(0, 2 * aw)) - aw;
        by = ay + int'($urandom_range(0, 2 * ah)) - ah;
      end
    endcase
    p.a_x = ax[COORD_BITS-1:0];
    p.a_y = ay[COORD_BITS-1:0];
    p.a_width = aw[COORD_BITS-2:0];
    p.a_height = ah[COORD_BITS-2:0];
    p.b_x = bx[COORD_BITS-1:0];
    p.b_y = by[COORD_BITS-1:0];
    p.b_width = bw[COORD_BITS-2:0];
    p.b_height = bh[COORD_BITS-2:0];
    return p;
  endfunction

  task automatic push_box_pair(box_pair_t p);
    int gap_len;
    gap_len = pick_gap();
    if (gap_len > 0) begin
      in_push = 1'b0;
      repeat (gap_len) @(negedge clk);
    end
    in_a_x = p.a_x;
    in_a_y = p.a_y;
    in_a_width = p.a_width;
    in_a_height = p.a_height;
    in_b_x = p.b_x;
    in_b_y = p.b_y;
    in_b_width = p.b_width;
    in_b_height = p.b_height;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    pending_ious.push_back(predict_iou(p));
    @(negedge clk);
  endtask

  task automatic push_boxes(int ax, int ay, int aw, int ah, int bx, int by, int bw, int bh);
    box_pair_t p;
    p.a_x = ax[COORD_BITS-1:0];
    p.a_y = ay[COORD_BITS-1:0];
    p.a_width = aw[COORD_BITS-2:0];
    p.a_height = ah[COORD_BITS-2:0];
    p.b_x = bx[COORD_BITS-1:0];
    p.b_y = by[COORD_BITS-1:0];
    p.b_width = bw[COORD_BITS-2:0];
    p.b_height = bh[COORD_BITS-2:0];
    push_box_pair(p);
  endtask

  task automatic wait_results_drained();
    while (pending_ious.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_corner_cases();
    push_boxes(10, 20, 30, 40, 10, 20, 30, 40);
    push_boxes(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    push_boxes(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    push_boxes(32767, 0, 32767, 10, 32766, 0, 2, 10);
    push_boxes(0, 0, 10, 10, 10, 0, 10, 10);
    push_boxes(0, 0, 10, 10, 0, 10, 10, 10);
    push_boxes(-100, -100, 5, 5, 100, 100, 5, 5);
    push_boxes(5, 5, 0, 10, 0, 0, 20, 20);
    push_boxes(3, 3, 0, 0, 3, 3, 0, 0);
    push_boxes(2, 2, 4, 4, 0, 0, 10, 10);
    push_boxes(0, 0, 10, 10, 2, 2, 4, 4);
    push_boxes(0, 0, 10, 10, 5, 5, 10, 10);
    push_boxes(-20, -20, 15, 15, -10, -10, 30, 30);
    push_boxes(-1, 0, 5, 5, 0, 0, 10, 10);
    push_boxes(-1, -1, 32767, 32767, -32768, -32768, 32767, 32767);
    push_boxes(-32768, -32768, 32767, 32767, -16384, -16384, 32767, 32767);
    push_boxes(-2, -2, 1, 1, -32768, -32768, 32767, 32767);
    push_boxes(0, 0, 32767, 1, 100, -5, 1, 32767);
    push_boxes(0, 0, 10, 10, 5, 5, 10, 0);
    push_boxes(32767, -32768, 0, 32767, -32768, 32767, 32767, 0);
  endtask

  task automatic test_random_pairs(int count);
    repeat (count) push_box_pair(random_box_pair());
  endtask

  task automatic test_back_to_back(int count);
    steady_flow = 1'b1;
    test_random_pairs(count);
    steady_flow = 1'b0;
  endtask

  task automatic test_drain_pause();
    test_random_pairs(50);
    in_push = 1'b0;
    wait_results_drained();
    test_random_pairs(50);
  endtask

  task automatic test_result_backpressure(int count);
    steady_flow = 1'b1;
    hold_results = 1'b1;
    fork
      begin
        do @(posedge clk); while (!in_full);
        @(negedge clk);
        hold_results = 1'b0;
      end
    join_none
    test_random_pairs(count);
    hold_results = 1'b0;
    steady_flow = 1'b0;
  endtask

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results || pop_stall > 0) begin
        out_pop = 1'b0;
        if (pop_stall > 0) pop_stall--;
      end else begin
        out_pop = 1'b1;
        pop_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    iou_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_ious.size() == 0) begin
        $error("unexpected result: out_iou %0d out_a_inside_b %0d", out_iou, out_a_inside_b);
        error_count++;
      end else begin
        want = pending_ious.pop_front();
        if (out_iou !== want.iou) begin
          $error("out_iou: expected %0d, got %0d", want.iou, out_iou);
          error_count++;
        end
        if (out_a_inside_b !== want.a_inside_b) begin
          $error("out_a_inside_b: expected %0d, got %0d", want.a_inside_b, out_a_inside_b);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_a_x = '0;
    in_a_y = '0;
    in_a_width = '0;
    in_a_height = '0;
    in_b_x = '0;
    in_b_y = '0;
    in_b_width = '0;
    in_b_height = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_corner_cases();
    test_random_pairs(800);
    test_back_to_back(300);
    test_drain_pause();
    test_result_backpressure(150);
    test_random_pairs(650);

    in_push = 1'b0;
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_ious.size() == 0) begin
      $display("box_iou_and_containment: match");
    end else begin
      $display("box_iou_and_containment: mismatch");
    end
    $finish;
  end

endmodule
